// ===== hdl/nsba_pkg.sv =====
// Shared types, constants and helper functions for the scaled blit address generator.
package nsba_pkg;

  localparam int unsigned MAX_DIM  = 16384;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned COORD_W  = 14;
  localparam int unsigned PROD_W   = 28;
  localparam int unsigned OFFSET_W = 27;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STRIDE_W = 17;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned ROWP_W   = COORD_W + STRIDE_W;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned QBITS    = PROD_W;

  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_FOUR_BYTE     = 3'd2,
    REG_ROW_ORDER     = 3'd3,
    REG_TARGET_WIDTH  = 3'd4,
    REG_TARGET_HEIGHT = 3'd5,
    REG_DEST_X        = 3'd6,
    REG_DEST_Y        = 3'd7
  } nsba_reg_e;

  // Clamped, derived config; user keeps it static while items are in flight (unchecked)
  typedef struct packed {
    logic [DIM_W-1:0]    sw;
    logic [DIM_W-1:0]    sh;
    logic [DIM_W-1:0]    tw;
    logic [DIM_W-1:0]    th;
    logic                scaled;
    logic                four;
    logic                top_first;
    logic [STRIDE_W-1:0] stride;
    logic [WORD_W-1:0]   dest_x;
    logic [WORD_W-1:0]   dest_y;
  } nsba_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               oor;
  } nsba_side_t;

  // Restoring divider lane: partial remainder plus dividend bits shifting out
  // at the top while quotient bits shift in at the bottom
  typedef struct packed {
    logic [DIM_W-1:0]  rem;
    logic [PROD_W-1:0] nq;
  } nsba_lane_t;

  typedef struct packed {
    nsba_side_t side;
    nsba_lane_t y;
    nsba_lane_t x;
  } nsba_div_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               oor;
  } nsba_sel_t;

  typedef struct packed {
    logic [ROWP_W-1:0] row_part;
    logic [PIX_W-1:0]  pix_part;
    logic [WORD_W-1:0] screen_x;
    logic [WORD_W-1:0] screen_y;
    logic              oor;
  } nsba_addr_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic lo_one);
    logic [DIM_W-1:0] r;
    r = v;
    if (lo_one && (v == '0)) r = DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic nsba_lane_t div_step(input nsba_lane_t l, input logic [DIM_W-1:0] d);
    logic [DIM_W:0] shifted;
    logic           ge;
    nsba_lane_t     r;
    shifted  = {l.rem, l.nq[PROD_W-1]};
    ge       = (shifted >= {1'b0, d});
    r.rem    = ge ? DIM_W'(shifted - {1'b0, d}) : shifted[DIM_W-1:0];
    r.nq     = {l.nq[PROD_W-2:0], ge};
    return r;
  endfunction

endpackage

// ===== hdl/nsba_if.sv =====
// Valid/ready channel interfaces for target coordinates and blit addresses.
interface nsba_in_if;
  logic                        valid;
  logic                        ready;
  logic [nsba_pkg::COORD_W-1:0] target_row;
  logic [nsba_pkg::COORD_W-1:0] target_column;

  modport source (output valid, output target_row, output target_column, input ready);
  modport sink   (input valid, input target_row, input target_column, output ready);
endinterface

interface nsba_out_if;
  logic                          valid;
  logic                          ready;
  logic [nsba_pkg::OFFSET_W-1:0] byte_offset;
  logic signed [nsba_pkg::WORD_W-1:0] screen_x;
  logic signed [nsba_pkg::WORD_W-1:0] screen_y;
  logic                          out_of_range;

  modport source (output valid, output byte_offset, output screen_x, output screen_y,
                  output out_of_range, input ready);
  modport sink   (input valid, input byte_offset, input screen_x, input screen_y,
                  input out_of_range, output ready);
endinterface

// ===== hdl/nsba_div_cell.sv =====
// One divider cell: a quotient bit for the row and column lanes per stage.
module nsba_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsba_pkg::nsba_cfg_t cfg_i,
  input  logic                up_valid_i,
  input  nsba_pkg::nsba_div_t up_data_i,
  output logic                up_ready_o,
  output logic                down_valid_o,
  output nsba_pkg::nsba_div_t down_data_o,
  input  logic                down_ready_i
);
  import nsba_pkg::*;

  logic      valid_q, valid_d;
  nsba_div_t data_q, data_d;
  logic      load;

  assign up_ready_o = !valid_q || down_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    data_d      = up_data_i;
    data_d.y    = div_step(up_data_i.y, cfg_i.th);
    data_d.x    = div_step(up_data_i.x, cfg_i.tw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign down_valid_o = valid_q;
  assign down_data_o  = data_q;

endmodule

// ===== hdl/nsba_tail.sv =====
// Clamp, row flip, offset multiply-add and result register after the divider chain.
module nsba_tail (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsba_pkg::nsba_cfg_t cfg_i,
  input  logic                up_valid_i,
  input  nsba_pkg::nsba_div_t up_data_i,
  output logic                up_ready_o,
  nsba_out_if.source          out_if
);
  import nsba_pkg::*;

  // Select stage
  logic      sel_valid_q, sel_valid_d, sel_ready, sel_load;
  nsba_sel_t sel_q, sel_d;
  // Multiply stage
  logic       addr_valid_q, addr_valid_d, addr_ready, addr_load;
  nsba_addr_t addr_q, addr_d;
  // Result register
  logic                out_valid_q, out_valid_d, out_load;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [WORD_W-1:0]   sx_q, sy_q;
  logic                oor_q, oor_d;

  logic [PROD_W-1:0] qy, qx;
  logic [DIM_W-1:0]  sy_full, sx_full, flip;
  logic [SUM_W-1:0]  sum;

  assign out_load   = addr_valid_q && (!out_valid_q || out_if.ready);
  assign addr_ready = !addr_valid_q || !out_valid_q || out_if.ready;
  assign addr_load  = sel_valid_q && addr_ready;
  assign sel_ready  = !sel_valid_q || addr_ready;
  assign sel_load   = up_valid_i && sel_ready;
  assign up_ready_o = sel_ready;

  always_comb begin
    sel_valid_d = sel_valid_q;
    if (sel_load) begin
      sel_valid_d = 1'b1;
    end else if (addr_ready) begin
      sel_valid_d = 1'b0;
    end
    addr_valid_d = addr_valid_q;
    if (addr_load) begin
      addr_valid_d = 1'b1;
    end else if (!out_valid_q || out_if.ready) begin
      addr_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Clamp scaled-mode quotients to the last source pixel and flip bottom-up rows
  always_comb begin
    qy = up_data_i.y.nq;
    qx = up_data_i.x.nq;
    if (cfg_i.scaled) begin
      sy_full = (qy >= PROD_W'(cfg_i.sh)) ? DIM_W'(cfg_i.sh - 1'b1) : qy[DIM_W-1:0];
      sx_full = (qx >= PROD_W'(cfg_i.sw)) ? DIM_W'(cfg_i.sw - 1'b1) : qx[DIM_W-1:0];
    end else begin
      sy_full = DIM_W'(up_data_i.side.row);
      sx_full = DIM_W'(up_data_i.side.col);
    end
    flip          = DIM_W'(cfg_i.sh - 1'b1 - sy_full);
    sel_d.src_row = cfg_i.top_first ? sy_full[COORD_W-1:0] : flip[COORD_W-1:0];
    sel_d.sx      = sx_full[COORD_W-1:0];
    sel_d.row     = up_data_i.side.row;
    sel_d.col     = up_data_i.side.col;
    sel_d.oor     = up_data_i.side.oor;
  end

  always_comb begin
    addr_d.row_part = ROWP_W'(sel_q.src_row) * ROWP_W'(cfg_i.stride);
    addr_d.pix_part = cfg_i.four ? {sel_q.sx, 2'b00}
                                 : PIX_W'({sel_q.sx, 1'b0}) + PIX_W'(sel_q.sx);
    addr_d.screen_x = cfg_i.dest_x + WORD_W'(sel_q.col);
    addr_d.screen_y = cfg_i.dest_y + WORD_W'(sel_q.row);
    addr_d.oor      = sel_q.oor;
  end

  // Drop offsets that do not fit the buffer
  always_comb begin
    sum      = SUM_W'(addr_q.row_part) + SUM_W'(addr_q.pix_part);
    oor_d    = addr_q.oor || (|sum[SUM_W-1:OFFSET_W]);
    offset_d = oor_d ? '0 : sum[OFFSET_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q  <= 1'b0;
      addr_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      sel_valid_q  <= sel_valid_d;
      addr_valid_q <= addr_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_load) begin
      sel_q <= sel_d;
    end
    if (addr_load) begin
      addr_q <= addr_d;
    end
    if (out_load) begin
      offset_q <= offset_d;
      sx_q     <= addr_q.screen_x;
      sy_q     <= addr_q.screen_y;
      oor_q    <= oor_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.byte_offset  = offset_q;
  assign out_if.screen_x     = sx_q;
  assign out_if.screen_y     = sy_q;
  assign out_if.out_of_range = oor_q;

endmodule

// ===== hdl/nearest_scaled_blit_address.sv =====
// Top level of the nearest-neighbor scaled blit address generator.
//
// Usage: write the source and target geometry, pixel format, row order and
// screen origin through the config port (cfg_we_i, cfg_idx_i, cfg_data_i)
// while no item is in flight. Then stream target (row, column) pairs on
// in_if; every transfer yields exactly one result on out_if with the byte
// offset of the source pixel, the screen position and an out-of-range flag.
// Target sizes both nonzero select scaling; otherwise coordinates map 1:1.
//
// An item passes, in order, the head register for the coordinate multiplies,
// 28 divider cells that each resolve one quotient bit of the row and column
// lanes, then clamp/flip, offset multiply and the result register.
// Throughput is one item per cycle while the receiver is ready, set by the
// one-bit-per-cell divider chain. Reset empties every stage and loads the
// default geometry (1x1 source, 1:1 mode, 3-byte pixels, bottom-up rows,
// origin 0). When the receiver stalls the result holds; upstream stages
// keep filling bubbles, so input is still taken until the chain is full.
module nearest_scaled_blit_address (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nsba_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [nsba_pkg::WORD_W-1:0]   cfg_data_i,
  nsba_in_if.sink                       in_if,
  nsba_out_if.source                    out_if
);
  import nsba_pkg::*;

  logic [DIM_W-1:0]  src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic              four_q, top_first_q;
  logic [WORD_W-1:0] dest_x_q, dest_y_q;

  nsba_cfg_t           cfg;
  logic [STRIDE_W-1:0] row_bytes, row_pad;

  logic      stage_valid [QBITS+1];
  logic      stage_ready [QBITS+1];
  nsba_div_t stage_data  [QBITS+1];

  logic      head_valid_q, head_valid_d, head_load;
  nsba_div_t head_q, head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= DIM_W'(1);
      src_h_q     <= DIM_W'(1);
      four_q      <= 1'b0;
      top_first_q <= 1'b0;
      tgt_w_q     <= '0;
      tgt_h_q     <= '0;
      dest_x_q    <= '0;
      dest_y_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (nsba_reg_e'(cfg_idx_i))
        REG_SOURCE_WIDTH:  src_w_q     <= cfg_data_i[DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_h_q     <= cfg_data_i[DIM_W-1:0];
        REG_FOUR_BYTE:     four_q      <= cfg_data_i[0];
        REG_ROW_ORDER:     top_first_q <= cfg_data_i[0];
        REG_TARGET_WIDTH:  tgt_w_q     <= cfg_data_i[DIM_W-1:0];
        REG_TARGET_HEIGHT: tgt_h_q     <= cfg_data_i[DIM_W-1:0];
        REG_DEST_X:        dest_x_q    <= cfg_data_i;
        REG_DEST_Y:        dest_y_q    <= cfg_data_i;
        default:           dest_y_q    <= dest_y_q;
      endcase
    end
  end

  // Saturate sizes and pad each stored row to a multiple of four bytes
  always_comb begin
    cfg.sw        = clamp_dim(src_w_q, 1'b1);
    cfg.sh        = clamp_dim(src_h_q, 1'b1);
    cfg.tw        = clamp_dim(tgt_w_q, 1'b0);
    cfg.th        = clamp_dim(tgt_h_q, 1'b0);
    cfg.scaled    = (cfg.tw != '0) && (cfg.th != '0);
    cfg.four      = four_q;
    cfg.top_first = top_first_q;
    row_bytes     = four_q ? {cfg.sw, 2'b00}
                           : STRIDE_W'({cfg.sw, 1'b0}) + STRIDE_W'(cfg.sw);
    row_pad       = row_bytes + STRIDE_W'(3);
    cfg.stride    = {row_pad[STRIDE_W-1:2], 2'b00};
    cfg.dest_x    = dest_x_q;
    cfg.dest_y    = dest_y_q;
  end

  // Head stage: scale coordinates by the source size and flag the drawn area
  assign in_if.ready = !head_valid_q || stage_ready[0];
  assign head_load   = in_if.valid && in_if.ready;

  always_comb begin
    head_d.y.rem    = '0;
    head_d.x.rem    = '0;
    head_d.y.nq     = PROD_W'(PROD_W'(in_if.target_row) * PROD_W'(cfg.sh));
    head_d.x.nq     = PROD_W'(PROD_W'(in_if.target_column) * PROD_W'(cfg.sw));
    head_d.side.row = in_if.target_row;
    head_d.side.col = in_if.target_column;
    if (cfg.scaled) begin
      head_d.side.oor = (DIM_W'(in_if.target_row) >= cfg.th) ||
                        (DIM_W'(in_if.target_column) >= cfg.tw);
    end else begin
      head_d.side.oor = (DIM_W'(in_if.target_row) >= cfg.sh) ||
                        (DIM_W'(in_if.target_column) >= cfg.sw);
    end
  end

  always_comb begin
    head_valid_d = head_valid_q;
    if (head_load) begin
      head_valid_d = 1'b1;
    end else if (stage_ready[0]) begin
      head_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_load) begin
      head_q <= head_d;
    end
  end

  assign stage_valid[0] = head_valid_q;
  assign stage_data[0]  = head_q;

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    nsba_div_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (cfg),
      .up_valid_i   (stage_valid[k]),
      .up_data_i    (stage_data[k]),
      .up_ready_o   (stage_ready[k]),
      .down_valid_o (stage_valid[k+1]),
      .down_data_o  (stage_data[k+1]),
      .down_ready_i (stage_ready[k+1])
    );
  end

  nsba_tail u_tail (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (stage_valid[QBITS]),
    .up_data_i  (stage_data[QBITS]),
    .up_ready_o (stage_ready[QBITS]),
    .out_if     (out_if)
  );

  a_oor_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.out_of_range |-> out_if.byte_offset == '0)
    else $error("out-of-range result carries a nonzero offset");

  a_word_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.out_of_range && four_q |-> out_if.byte_offset[1:0] == 2'b00)
    else $error("four-byte pixel offset not word aligned");

  a_inside_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.out_of_range |->
      (SUM_W'(out_if.byte_offset) < SUM_W'(cfg.stride) * SUM_W'(cfg.sh)))
    else $error("offset beyond the source pixel buffer");

endmodule
